### hdl/ip_access_control_table_defines.svh
// ----------------------------------------------------------------------------
// IP access control table: assertion macros
// Shared assertion macros for the access control table RTL.
// ----------------------------------------------------------------------------
`ifndef IP_ACCESS_CONTROL_TABLE_DEFINES_SVH
`define IP_ACCESS_CONTROL_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define ACL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ACL_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ACL_ASSERT(label, prop, msg)
`define ACL_ASSERT_RST(label, prop, msg)
`endif

`endif

### hdl/acl_pkg.sv
// ----------------------------------------------------------------------------
// Access control table package
// Sizes, operation and status codes, and the types shared by the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package acl_pkg;

	localparam int MAX_RULES   = 64;
	localparam int IDX_W       = $clog2(MAX_RULES);
	localparam int CNT_W       = $clog2(MAX_RULES + 1);
	localparam int ADDR_W      = 32;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 3;
	localparam int POS_W       = 6;
	localparam int COUNT_OUT_W = 7;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP_SAME  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DUP_OTHER = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] addr;
		logic              allow;
		logic [ADDR_W-1:0] query;
	} cmd_t;

	typedef struct packed {
		logic [ADDR_W-1:0] mask;
		logic [ADDR_W-1:0] addr;
		logic              allow;
	} rule_t;

	typedef struct packed {
		logic gt;
		logic eq;
		logic same;
		logic hit;
		logic hit_allow;
	} flags_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} upd_t;

endpackage

`default_nettype wire

### hdl/ip_access_control_table.sv
// ----------------------------------------------------------------------------
// IP access control table
// Sorted IPv4 address/mask rule table with insert, remove and lookup.
// ----------------------------------------------------------------------------
// Usage:
// A transaction is accepted on a rising edge with start high and busy low;
// op selects insert, remove or lookup, and the entry and query fields travel
// with it. One result appears on the result ports for a single cycle, marked
// by done, after the compare and apply states. The receiver cannot stall it.
// Each transaction passes through a compare state, in which every cell
// compares its rule with the transaction, and an apply state, in which the
// flags of the row are resolved and the row shifts. busy is high only in the
// compare state, so a new transaction may be accepted in the apply state.
// The default verdict register is written with cfg_we and cfg_wdata. The
// user must write it only while no transaction is in flight (not enforced).
// Reset empties the table and clears the default verdict to deny; the rule
// storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_access_control_table_defines.svh"

module ip_access_control_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [acl_pkg::OP_W-1:0]           op,
	input  logic [acl_pkg::ADDR_W-1:0]         entry_address,
	input  logic [acl_pkg::ADDR_W-1:0]         entry_mask,
	input  logic                               entry_allow,
	input  logic [acl_pkg::ADDR_W-1:0]         query_address,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	output logic                               done,
	output logic [acl_pkg::STATUS_W-1:0]       status,
	output logic                               allowed,
	output logic                               matched,
	output logic [acl_pkg::POS_W-1:0]          match_position,
	output logic [acl_pkg::COUNT_OUT_W-1:0]    entry_count
);
	import acl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_APPLY
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    default_allow_q;
	logic                    accept;
	upd_t                    upd;

	rule_t                   rules [MAX_RULES];
	flags_t                  flags [MAX_RULES];
	logic [MAX_RULES-1:0]    eq_vec;
	logic [MAX_RULES-1:0]    same_vec;
	logic [MAX_RULES-1:0]    hit_vec;
	logic [MAX_RULES-1:0]    hit_allow_vec;
	logic [MAX_RULES-1:0]    first_oh;
	logic [IDX_W-1:0]        first_pos;

	logic                    invalid_ins;
	logic                    any_eq;
	logic                    full;
	logic                    do_ins;
	logic                    do_rem;
	logic [STATUS_W-1:0]     status_d;
	logic                    allowed_d;
	logic                    matched_d;
	logic [POS_W-1:0]        pos_d;

	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic                    allowed_q;
	logic                    matched_q;
	logic [POS_W-1:0]        pos_q;
	logic [COUNT_OUT_W-1:0]  count_out_q;

	assign busy   = (state_q == S_CMP);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q.op    <= op;
			cmd_q.mask  <= entry_mask;
			cmd_q.addr  <= entry_address & entry_mask;
			cmd_q.allow <= entry_allow;
			cmd_q.query <= query_address;
		end
	end

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		logic  valid;
		logic  prev_gt;
		rule_t prev_rule;
		rule_t next_rule;

		assign valid = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign prev_gt   = 1'b1;
			assign prev_rule = rules[i];
		end else begin : g_mid
			assign prev_gt   = flags[i-1].gt;
			assign prev_rule = rules[i-1];
		end

		if (i == MAX_RULES - 1) begin : g_last
			assign next_rule = rules[i];
		end else begin : g_inner
			assign next_rule = rules[i+1];
		end

		acl_cell u_cell (
			.clk       (clk),
			.cmd       (cmd_q),
			.valid     (valid),
			.upd       (upd),
			.prev_gt   (prev_gt),
			.prev_rule (prev_rule),
			.next_rule (next_rule),
			.rule      (rules[i]),
			.flags     (flags[i])
		);

		assign eq_vec[i]        = flags[i].eq;
		assign same_vec[i]      = flags[i].same;
		assign hit_vec[i]       = flags[i].hit;
		assign hit_allow_vec[i] = flags[i].hit_allow;
	end

	assign first_oh = hit_vec & (~hit_vec + MAX_RULES'(1));

	always_comb begin
		first_pos = '0;
		for (int i = 0; i < MAX_RULES; i++) begin
			if (first_oh[i]) begin
				first_pos = first_pos | IDX_W'(i);
			end
		end
	end

	always_comb begin
		invalid_ins = (cmd_q.addr == '0) && (cmd_q.mask != '0);
		any_eq      = |eq_vec;
		full        = (count_q == CNT_W'(MAX_RULES));
		do_ins      = (cmd_q.op == OP_INSERT) && !invalid_ins && !any_eq && !full;
		do_rem      = (cmd_q.op == OP_REMOVE) && any_eq;
		upd.ins     = (state_q == S_APPLY) && do_ins;
		upd.rem     = (state_q == S_APPLY) && do_rem;

		if (do_ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_next = count_q - CNT_W'(1);
		end else begin
			count_next = count_q;
		end

		allowed_d = 1'b0;
		matched_d = 1'b0;
		pos_d     = '0;
		case (cmd_q.op)
			OP_INSERT: begin
				if (invalid_ins) begin
					status_d = ST_INVALID;
				end else if (any_eq) begin
					status_d = (|same_vec) ? ST_DUP_SAME : ST_DUP_OTHER;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_DONE;
				end
			end
			OP_REMOVE: begin
				status_d = any_eq ? ST_DONE : ST_NOT_FOUND;
			end
			OP_LOOKUP: begin
				status_d = ST_DONE;
				if (count_q == '0) begin
					allowed_d = default_allow_q;
				end else begin
					allowed_d = |(first_oh & hit_allow_vec);
					matched_d = |hit_vec;
					pos_d     = POS_W'(first_pos);
				end
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q         <= '0;
			default_allow_q <= 1'b0;
		end else begin
			if (state_q == S_APPLY) begin
				count_q <= count_next;
			end
			if (cfg_we) begin
				default_allow_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			done_q      <= 1'b0;
			status_q    <= ST_DONE;
			allowed_q   <= 1'b0;
			matched_q   <= 1'b0;
			pos_q       <= '0;
			count_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					done_q      <= 1'b1;
					status_q    <= status_d;
					allowed_q   <= allowed_d;
					matched_q   <= matched_d;
					pos_q       <= pos_d;
					count_out_q <= COUNT_OUT_W'(count_next);
					state_q     <= accept ? S_CMP : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign allowed        = allowed_q;
	assign matched        = matched_q;
	assign match_position = pos_q;
	assign entry_count    = count_out_q;

	`ACL_ASSERT_RST(a_reset_quiet, !arst_n |=> !done && !busy, "Result or busy seen in reset.")
	`ACL_ASSERT(a_accept_busy, start && !busy |=> busy, "Accepted transaction did not raise busy.")
	`ACL_ASSERT(a_busy_done, busy |=> ##1 done, "Transaction gave no result two cycles on.")
	`ACL_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_RULES), "Rule count exceeds the table size.")
	`ACL_ASSERT(a_match_status, done && matched |-> status == ST_DONE && entry_count != '0, "Match reported without rules.")

endmodule

`default_nettype wire

### hdl/acl_cell.sv
// ----------------------------------------------------------------------------
// Access control table cell
// Holds one rule, compares it against the current transaction and shifts
// rules to or from its neighbours on an insert or a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module acl_cell (
	input  logic            clk,
	input  acl_pkg::cmd_t   cmd,
	input  logic            valid,
	input  acl_pkg::upd_t   upd,
	input  logic            prev_gt,
	input  acl_pkg::rule_t  prev_rule,
	input  acl_pkg::rule_t  next_rule,
	output acl_pkg::rule_t  rule,
	output acl_pkg::flags_t flags
);
	import acl_pkg::*;

	rule_t  rule_q;
	flags_t flags_d;
	flags_t flags_s1;

	always_comb begin
		flags_d.gt = valid && ((rule_q.mask > cmd.mask) ||
			((rule_q.mask == cmd.mask) && (rule_q.addr > cmd.addr)));
		flags_d.eq = valid && (rule_q.mask == cmd.mask) && (rule_q.addr == cmd.addr);
		flags_d.same = flags_d.eq && (rule_q.allow == cmd.allow);
		flags_d.hit = valid && ((cmd.query & rule_q.mask) == rule_q.addr);
		flags_d.hit_allow = flags_d.hit && rule_q.allow;
	end

	always_ff @(posedge clk) begin
		flags_s1 <= flags_d;
		if (upd.ins) begin
			if (!prev_gt) begin
				rule_q <= prev_rule;
			end else if (!flags_s1.gt) begin
				rule_q <= '{mask: cmd.mask, addr: cmd.addr, allow: cmd.allow};
			end
		end else if (upd.rem && !flags_s1.gt) begin
			rule_q <= next_rule;
		end
	end

	assign rule  = rule_q;
	assign flags = flags_s1;

endmodule

`default_nettype wire
